/* rtl/rsp_pkg.sv */
`default_nettype none
package rsp_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int COORD_W   = 24;
    localparam int RAD_W     = 23;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int MAG_W     = PROD_W;
    localparam int HALF_W    = MAG_W / 2;
    localparam int RSQ_W     = 2 * RAD_W;
    localparam int DLEN_W    = PROD_W + 2;
    localparam int SQ_W      = 2 * MAG_W + 4;
    localparam int OUT_IDX_W = 6;

    // Operand splits for the wide squares in the hit test.
    localparam int RL_W = RSQ_W / 2;
    localparam int RH_W = RSQ_W - RL_W;
    localparam int DL_W = DLEN_W / 2;
    localparam int DH_W = DLEN_W - DL_W;
    localparam int LH_W = MAG_W - HALF_W;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [COORD_W-1:0]  a_x;
        logic signed [COORD_W-1:0]  a_y;
        logic signed [COORD_W-1:0]  a_z;
        logic signed [COORD_W-1:0]  b_x;
        logic signed [COORD_W-1:0]  b_y;
        logic signed [COORD_W-1:0]  b_z;
        logic [RAD_W-1:0]           sphere_radius;
    } t_in_item;

    typedef struct packed {
        logic                   hit;
        logic [OUT_IDX_W-1:0]   entry_index;
        logic                   status;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [RAD_W-1:0]           r;
    } t_entry;

    typedef struct packed {
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  az;
        logic signed [DIFF_W-1:0]   dx;
        logic signed [DIFF_W-1:0]   dy;
        logic signed [DIFF_W-1:0]   dz;
        logic [DLEN_W-1:0]          dlen2;
    } t_query;

    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic               last;
        logic [IDX_W-1:0]   index;
    } t_tag;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [IDX_W-1:0]   index;
    } t_eval_res;

endpackage
`default_nettype wire

/* rtl/rsp_in_if.sv */
`default_nettype none
interface rsp_in_if import rsp_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/rsp_out_if.sv */
`default_nettype none
interface rsp_out_if import rsp_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/rsp_cell.sv */
`default_nettype none
// One table slot of the sphere ring. It takes its neighbor's entry on a shift.
module rsp_cell import rsp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_shift,
    input  wire logic   i_load,
    input  wire t_entry i_next,
    input  wire t_entry i_wdata,
    output t_entry      o_entry
);
    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_wdata;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

/* rtl/rsp_eval.sv */
`default_nettype none
// Pipelined hit test for one entry per cycle, followed by the nearest-hit tracker.
module rsp_eval import rsp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_clear,
    input  wire t_tag   i_tag,
    input  wire t_entry i_entry,
    input  wire t_query i_query,
    output t_eval_res   o_res
);
    // Stage 1: offsets from the ray start.
    t_tag                     r1_tag;
    logic signed [DIFF_W-1:0] r1_wx, r1_wy, r1_wz;
    logic [RAD_W-1:0]         r1_r;
    // Stage 2: all pairwise products.
    t_tag                     r2_tag;
    logic signed [PROD_W-1:0] r2_xx, r2_yy, r2_zz, r2_yz, r2_zy, r2_zx, r2_xz, r2_xy, r2_yx;
    logic [RSQ_W-1:0]         r2_rsq;
    // Stage 3: dot product and cross product magnitudes.
    t_tag                     r3_tag;
    logic signed [DOT_W-1:0]  r3_dot;
    logic [MAG_W-1:0]         r3_mx, r3_my, r3_mz;
    logic [RSQ_W-1:0]         r3_rsq;
    // Stage 4: partial products of the squares.
    t_tag                     r4_tag;
    logic signed [DOT_W-1:0]  r4_dot;
    logic [2*LH_W-1:0]        r4_hh [3];
    logic [2*HALF_W-1:0]      r4_hl [3];
    logic [2*HALF_W-1:0]      r4_ll [3];
    logic [RH_W+DH_W-1:0]     r4_rhdh;
    logic [RH_W+DL_W-1:0]     r4_rhdl;
    logic [RL_W+DH_W-1:0]     r4_rldh;
    logic [RL_W+DL_W-1:0]     r4_rldl;
    // Stage 5: full squares and scaled radius.
    t_tag                     r5_tag;
    logic signed [DOT_W-1:0]  r5_dot;
    logic [SQ_W-1:0]          r5_sq [3];
    logic [SQ_W-1:0]          r5_rhs;
    // Stage 6: perpendicular distance sum.
    t_tag                     r6_tag;
    logic signed [DOT_W-1:0]  r6_dot;
    logic [SQ_W-1:0]          r6_lhs;
    logic [SQ_W-1:0]          r6_rhs;
    // Stage 7: hit decision.
    t_tag                     r7_tag;
    logic signed [DOT_W-1:0]  r7_dot;
    logic                     r7_le;
    // Tracker.
    logic                     r_found;
    logic signed [DOT_W-1:0]  r_best;
    logic [IDX_W-1:0]         r_index;
    logic                     r_done;

    logic signed [PROD_W:0]   w_cx, w_cy, w_cz;
    logic signed [PROD_W:0]   w_ax, w_ay, w_az;
    logic [MAG_W-1:0]         w_m [3];
    logic                     w_take;

    always_comb begin
        w_cx = {r2_yz[PROD_W-1], r2_yz} - {r2_zy[PROD_W-1], r2_zy};
        w_cy = {r2_zx[PROD_W-1], r2_zx} - {r2_xz[PROD_W-1], r2_xz};
        w_cz = {r2_xy[PROD_W-1], r2_xy} - {r2_yx[PROD_W-1], r2_yx};
        w_ax = w_cx[PROD_W] ? -w_cx : w_cx;
        w_ay = w_cy[PROD_W] ? -w_cy : w_cy;
        w_az = w_cz[PROD_W] ? -w_cz : w_cz;
    end

    always_comb begin
        w_m[0] = r3_mx;
        w_m[1] = r3_my;
        w_m[2] = r3_mz;
    end

    // An entry wins when it hits and is strictly nearer, so ties keep the earlier one.
    assign w_take = r7_tag.valid && r7_tag.in_range && !r7_dot[DOT_W-1] && r7_le
                    && (!r_found || (r7_dot < r_best));

    always_ff @(posedge i_clk) begin
        r1_tag <= i_rst_n ? i_tag : '0;
        r1_wx  <= DIFF_W'(i_entry.x) - DIFF_W'(i_query.ax);
        r1_wy  <= DIFF_W'(i_entry.y) - DIFF_W'(i_query.ay);
        r1_wz  <= DIFF_W'(i_entry.z) - DIFF_W'(i_query.az);
        r1_r   <= i_entry.r;

        r2_tag <= i_rst_n ? r1_tag : '0;
        r2_xx  <= r1_wx * i_query.dx;
        r2_yy  <= r1_wy * i_query.dy;
        r2_zz  <= r1_wz * i_query.dz;
        r2_yz  <= r1_wy * i_query.dz;
        r2_zy  <= r1_wz * i_query.dy;
        r2_zx  <= r1_wz * i_query.dx;
        r2_xz  <= r1_wx * i_query.dz;
        r2_xy  <= r1_wx * i_query.dy;
        r2_yx  <= r1_wy * i_query.dx;
        r2_rsq <= r1_r * r1_r;

        r3_tag <= i_rst_n ? r2_tag : '0;
        r3_dot <= DOT_W'(r2_xx) + DOT_W'(r2_yy) + DOT_W'(r2_zz);
        r3_mx  <= w_ax[MAG_W-1:0];
        r3_my  <= w_ay[MAG_W-1:0];
        r3_mz  <= w_az[MAG_W-1:0];
        r3_rsq <= r2_rsq;

        r4_tag <= i_rst_n ? r3_tag : '0;
        r4_dot <= r3_dot;
        for (int k = 0; k < 3; k++) begin
            r4_hh[k] <= w_m[k][MAG_W-1:HALF_W] * w_m[k][MAG_W-1:HALF_W];
            r4_hl[k] <= (2*HALF_W)'(w_m[k][MAG_W-1:HALF_W]) * w_m[k][HALF_W-1:0];
            r4_ll[k] <= w_m[k][HALF_W-1:0] * w_m[k][HALF_W-1:0];
        end
        r4_rhdh <= r3_rsq[RSQ_W-1:RL_W] * i_query.dlen2[DLEN_W-1:DL_W];
        r4_rhdl <= r3_rsq[RSQ_W-1:RL_W] * i_query.dlen2[DL_W-1:0];
        r4_rldh <= r3_rsq[RL_W-1:0] * i_query.dlen2[DLEN_W-1:DL_W];
        r4_rldl <= r3_rsq[RL_W-1:0] * i_query.dlen2[DL_W-1:0];

        r5_tag <= i_rst_n ? r4_tag : '0;
        r5_dot <= r4_dot;
        for (int k = 0; k < 3; k++) begin
            r5_sq[k] <= (SQ_W'(r4_hh[k]) << (2 * HALF_W))
                        + (SQ_W'(r4_hl[k]) << (HALF_W + 1))
                        + SQ_W'(r4_ll[k]);
        end
        r5_rhs <= (SQ_W'(r4_rhdh) << (RL_W + DL_W)) + (SQ_W'(r4_rhdl) << RL_W)
                  + (SQ_W'(r4_rldh) << DL_W) + SQ_W'(r4_rldl);

        r6_tag <= i_rst_n ? r5_tag : '0;
        r6_dot <= r5_dot;
        r6_lhs <= r5_sq[0] + r5_sq[1] + r5_sq[2];
        r6_rhs <= r5_rhs;

        r7_tag <= i_rst_n ? r6_tag : '0;
        r7_dot <= r6_dot;
        r7_le  <= (r6_lhs <= r6_rhs);

        if (w_take) begin
            r_best  <= r7_dot;
            r_index <= r7_tag.index;
        end

        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= r7_tag.valid && r7_tag.last;
            if (i_clear) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.found = r_found;
    assign o_res.index = r_found ? r_index : '0;
endmodule
`default_nettype wire

/* rtl/ray_sphere_pick.sv */
`default_nettype none
// Nearest-hit ray pick over a table of up to CAPACITY spheres.
//
// Input channel i_in carries one command beat: op selects clear, append or
// query; a_* is the sphere centre or the ray start, b_* the ray end and
// sphere_radius the radius of an appended sphere. Output channel o_out
// returns exactly one beat per command: hit, entry_index and status.
//
// Spheres sit in a ring of cells, cell 0 at the head. A query rotates the
// ring once, feeding one entry per cycle into a 7-stage test pipeline and
// the nearest-hit tracker; the ring rotation sets how long a query takes.
// Clear and append go from accept straight to S_PUSH and the output
// register. One command is in work at a time.
//
// The result sits in an output register; a new command is accepted while
// it waits. If the receiver stalls, the next result waits in the block and
// i_in stays not ready until the output register frees up.
//
// Reset empties the table; the ring contents themselves are not cleared.
module ray_sphere_pick import rsp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rsp_in_if.sink      i_in,
    rsp_out_if.source   o_out
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_SCAN,
        S_DRAIN,
        S_PUSH
    } t_state;

    t_state                     r_state;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_scan;
    t_query                     r_q;
    logic signed [PROD_W-1:0]   r_dsq_x, r_dsq_y, r_dsq_z;
    t_out_item                  r_res;
    t_out_item                  r_out;
    logic                       r_out_valid;
    logic                       r_clear;

    t_entry                     w_cell [CAPACITY];
    t_entry                     w_wdata;
    t_tag                       w_tag;
    t_eval_res                  w_res;
    logic                       w_accept;
    logic                       w_append;
    logic                       w_shift;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_append   = w_accept && (i_in.data.op == OP_APPEND)
                        && (r_count < CNT_W'(CAPACITY));
    assign w_shift    = (r_state == S_SCAN);

    assign w_wdata.x = i_in.data.a_x;
    assign w_wdata.y = i_in.data.a_y;
    assign w_wdata.z = i_in.data.a_z;
    assign w_wdata.r = i_in.data.sphere_radius;

    // Ring: each cell takes its upper neighbor's entry, the last takes the head's.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_ring
        rsp_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_load  (w_append && (r_count == CNT_W'(g))),
            .i_next  (w_cell[(g + 1) % CAPACITY]),
            .i_wdata (w_wdata),
            .o_entry (w_cell[g])
        );
    end

    // Entries at or beyond the fill count, and every entry of a zero-length
    // ray, travel through the pipeline but can never be picked.
    assign w_tag.valid    = w_shift;
    assign w_tag.in_range = (r_scan < r_count) && (r_q.dlen2 != '0);
    assign w_tag.last     = (r_scan == CNT_W'(CAPACITY - 1));
    assign w_tag.index    = r_scan[IDX_W-1:0];

    rsp_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (r_clear),
        .i_tag   (w_tag),
        .i_entry (w_cell[0]),
        .i_query (r_q),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
            r_clear     <= 1'b0;
        end else begin
            // The tracker is cleared just as the scan starts.
            r_clear <= (r_state == S_SUM);
            if ((r_state == S_PUSH) && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res.hit         <= 1'b0;
                        r_res.entry_index <= '0;
                        r_res.status      <= (i_in.data.op == OP_APPEND)
                                             && (r_count >= CNT_W'(CAPACITY));
                        case (i_in.data.op)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_PUSH;
                            end
                            OP_APPEND: begin
                                if (r_count < CNT_W'(CAPACITY)) begin
                                    r_count <= r_count + 1'b1;
                                end
                                r_state <= S_PUSH;
                            end
                            OP_QUERY: begin
                                r_q.ax  <= i_in.data.a_x;
                                r_q.ay  <= i_in.data.a_y;
                                r_q.az  <= i_in.data.a_z;
                                r_q.dx  <= DIFF_W'(i_in.data.b_x) - DIFF_W'(i_in.data.a_x);
                                r_q.dy  <= DIFF_W'(i_in.data.b_y) - DIFF_W'(i_in.data.a_y);
                                r_q.dz  <= DIFF_W'(i_in.data.b_z) - DIFF_W'(i_in.data.a_z);
                                r_state <= S_SQUARE;
                            end
                            default: begin
                                r_state <= S_PUSH;
                            end
                        endcase
                    end
                end
                S_SQUARE: begin
                    r_dsq_x <= r_q.dx * r_q.dx;
                    r_dsq_y <= r_q.dy * r_q.dy;
                    r_dsq_z <= r_q.dz * r_q.dz;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_q.dlen2 <= DLEN_W'(unsigned'(r_dsq_x)) + DLEN_W'(unsigned'(r_dsq_y))
                                 + DLEN_W'(unsigned'(r_dsq_z));
                    r_scan    <= '0;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    r_scan <= r_scan + 1'b1;
                    if (w_tag.last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_res.done) begin
                        r_res.hit         <= w_res.found;
                        r_res.entry_index <= OUT_IDX_W'(w_res.index);
                        r_state           <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule
`default_nettype wire

/* rtl/rsp_checker.sv */
`default_nettype none
module rsp_checker import rsp_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire logic [1:0] i_in_op,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);
    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.hit |-> i_out_data.entry_index == '0)
        else $error("miss with nonzero index");

    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status |-> !i_out_data.hit)
        else $error("hit reported with full status");

    // A table command with a free output register is answered without a stall.
    a_cmd_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid
        && (i_in_op == OP_CLEAR || i_in_op == OP_APPEND)
        |-> ##2 i_out_valid)
        else $error("table command result late");
endmodule

bind ray_sphere_pick rsp_checker u_rsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.data.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire
